// ===== hw/rtl/mte_pkg.sv =====
// ----------------------------------------------------------------------------
// mte_pkg
// Shared widths, constants and register indexes of the multi-tap echo core.
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

	// default sizing of the history
	localparam int HIST_FRAMES_DEF = 32768;
	localparam int MAX_CH_DEF      = 8;

	// fixed arithmetic settings
	localparam int MAX_REPEATS    = 8;
	localparam int GAIN_FRAC_BITS = 14;

	// field widths
	localparam int SAMPLE_W    = 32;
	localparam int DELAY_W     = 15;
	localparam int GAIN_REG_W  = 16;
	localparam int REPEAT_W    = 4;
	localparam int CHAN_W      = 4;
	localparam int MAX_SAMPLE_W = 31;
	localparam int GAIN_W      = 31;
	localparam int ACC_W       = 64;
	localparam int TAP_CNT_W   = REPEAT_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEATS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd5;

	// register reset values
	localparam logic [DELAY_W-1:0]       DELAY_RST    = 15'd1;
	localparam logic [GAIN_REG_W-1:0]    GAIN_RST     = 16'd8192;
	localparam logic [REPEAT_W-1:0]      REPEATS_RST  = 4'd1;
	localparam logic [CHAN_W-1:0]        CHANNELS_RST = 4'd1;
	localparam logic [SAMPLE_W-1:0]      MIN_RST      = 32'hFFFF_8000;
	localparam logic [MAX_SAMPLE_W-1:0]  MAX_RST      = 31'd32767;

	// gain and accumulator saturation
	localparam logic [GAIN_W-1:0] GAIN_CAP  = {GAIN_W{1'b1}};
	localparam logic signed [ACC_W-1:0] ACC_LIMIT = 64'sh4000_0000_0000_0000;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

endpackage

`default_nettype wire

// ===== hw/rtl/mte_front.sv =====
// ----------------------------------------------------------------------------
// mte_front
// Input side: tracks write pointer, frame and channel position of each
// accepted sample and tags it for the tap engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_front #(
	parameter int HISTORY_FRAMES = mte_pkg::HIST_FRAMES_DEF,
	parameter int MAX_CHANNELS   = mte_pkg::MAX_CH_DEF,
	localparam int DEPTH = HISTORY_FRAMES * MAX_CHANNELS,
	localparam int AW    = $clog2(DEPTH),
	localparam int FW    = $clog2(HISTORY_FRAMES + 1),
	localparam int CW    = $clog2(MAX_CHANNELS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        last_in,
	input  logic [mte_pkg::CHAN_W-1:0]  channel_count,
	output logic [AW-1:0]               wp,
	output logic [FW-1:0]               fidx,
	output logic [CW-1:0]               nch
);
	import mte_pkg::*;

	logic [AW-1:0] wp_q;
	logic [FW-1:0] fidx_q;
	logic [CW-1:0] ch_q;
	logic [CW-1:0] ch_nxt;

	always_comb begin
		if (channel_count == '0) begin
			nch = CW'(1);
		end else if (int'(channel_count) > MAX_CHANNELS) begin
			nch = CW'(MAX_CHANNELS);
		end else begin
			nch = CW'(channel_count);
		end
		ch_nxt = ch_q + CW'(1);
	end

	assign wp   = wp_q;
	assign fidx = fidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fidx_q <= '0;
			ch_q   <= '0;
		end else if (accept) begin
			if (last_in) begin
				// clip ends: restart all position counters
				wp_q   <= '0;
				fidx_q <= '0;
				ch_q   <= '0;
			end else begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
				if (ch_nxt >= nch) begin
					ch_q <= '0;
					if (fidx_q < FW'(HISTORY_FRAMES)) begin
						fidx_q <= fidx_q + FW'(1);
					end
				end else begin
					ch_q <= ch_nxt;
				end
			end
		end
	end

	a_clip_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_in |=> wp_q == '0 && fidx_q == '0 && ch_q == '0)
		else $error("position counters not cleared after last beat");

endmodule

`default_nettype wire

// ===== hw/rtl/mte_fifo.sv =====
// ----------------------------------------------------------------------------
// mte_fifo
// Short queue that decouples the input side from the tap engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_fifo #(
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              rd,
	output logic [DATA_W-1:0] rdata,
	output logic              empty
);
	import mte_pkg::*;

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(do_wr) - QCNT_W'(do_rd);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/mte_back.sv =====
// ----------------------------------------------------------------------------
// mte_back
// Tap engine: walks the echo taps one at a time through the history memory,
// accumulates gain-weighted taps, rounds, clamps and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_back #(
	parameter int HISTORY_FRAMES = mte_pkg::HIST_FRAMES_DEF,
	parameter int MAX_CHANNELS   = mte_pkg::MAX_CH_DEF,
	localparam int DEPTH = HISTORY_FRAMES * MAX_CHANNELS,
	localparam int AW    = $clog2(DEPTH),
	localparam int FW    = $clog2(HISTORY_FRAMES + 1),
	localparam int CW    = $clog2(MAX_CHANNELS + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// queue side
	input  logic                               q_empty,
	output logic                               q_pop,
	input  logic signed [mte_pkg::SAMPLE_W-1:0] e_sample,
	input  logic                               e_last,
	input  logic [AW-1:0]                      e_wp,
	input  logic [FW-1:0]                      e_fidx,
	input  logic [CW-1:0]                      e_nch,
	// configuration
	input  logic [mte_pkg::DELAY_W-1:0]        tap_spacing,
	input  logic [mte_pkg::GAIN_REG_W-1:0]     tap_gain,
	input  logic [mte_pkg::REPEAT_W-1:0]       repeat_count,
	input  logic signed [mte_pkg::SAMPLE_W-1:0] min_sample,
	input  logic [mte_pkg::MAX_SAMPLE_W-1:0]   max_sample,
	// result side
	input  logic                               pop,
	output logic                               empty,
	output logic signed [mte_pkg::SAMPLE_W-1:0] sample_out,
	output logic                               last_out
);
	import mte_pkg::*;

	localparam int DIST_W = ((FW > DELAY_W) ? FW : DELAY_W) + 1;
	localparam int OFF_W  = DIST_W + CW;
	localparam int OW     = ((OFF_W > AW + 1) ? OFF_W : AW + 1) + 1;
	localparam int GP_W   = GAIN_W + GAIN_REG_W;
	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (GAIN_FRAC_BITS - 1);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_TAP_RD  = 8'b0000_0010,
		S_TAP_MUL = 8'b0000_0100,
		S_TAP_ACC = 8'b0000_1000,
		S_ABS     = 8'b0001_0000,
		S_RND     = 8'b0010_0000,
		S_SIGN    = 8'b0100_0000,
		S_CLAMP   = 8'b1000_0000
	} bk_state_t;

	bk_state_t state_q;

	logic [SAMPLE_W-1:0]     mem [DEPTH];
	logic [SAMPLE_W-1:0]     rd_q;

	logic [SAMPLE_W-1:0]     smp_q;
	logic                    last_q;
	logic [AW-1:0]           wp_q;
	logic [FW-1:0]           fidx_q;
	logic [TAP_CNT_W-1:0]    k_q;
	logic [DIST_W-1:0]       dist_q;
	logic [OFF_W-1:0]        off_q;
	logic [OFF_W-1:0]        step_q;
	logic [GAIN_W-1:0]       g_q;
	logic [GP_W-1:0]         gprod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_q;
	logic [ACC_W-1:0]        mag_q;
	logic                    neg_q;
	logic signed [ACC_W-1:0] res_q;

	logic                    out_valid_q;
	logic [SAMPLE_W-1:0]     sample_out_q;
	logic                    last_out_q;

	logic [REPEAT_W-1:0]     reps_eff;
	logic                    tap_ok;
	logic [OW-1:0]           wp_ext;
	logic [OW-1:0]           off_ext;
	logic [AW-1:0]           rd_addr;
	logic [OFF_W-1:0]        step_new;
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ACC_W-1:0] acc_sat;
	logic [GP_W:0]           g_rnd;
	logic [GP_W:0]           g_shr;
	logic [GAIN_W-1:0]       g_next;
	logic signed [ACC_W-1:0] lo;
	logic signed [ACC_W-1:0] hi;
	logic signed [ACC_W-1:0] res_cl;
	logic                    out_free;
	logic                    mem_re;
	logic                    mem_we;

	always_comb begin
		reps_eff = (int'(repeat_count) > MAX_REPEATS) ? REPEAT_W'(MAX_REPEATS)
			: repeat_count;
		tap_ok = (tap_spacing != '0) && (k_q <= TAP_CNT_W'(reps_eff))
			&& (dist_q <= DIST_W'(fidx_q));

		// tap entry sits off entries behind the write pointer, modulo depth
		wp_ext  = OW'(wp_q);
		off_ext = OW'(off_q);
		if (wp_ext >= off_ext) begin
			rd_addr = AW'(wp_ext - off_ext);
		end else begin
			rd_addr = AW'(wp_ext + OW'(DEPTH) - off_ext);
		end

		step_new = OFF_W'(tap_spacing) * OFF_W'(e_nch);

		acc_sum = acc_q + prod_q;
		if (acc_sum > ACC_LIMIT) begin
			acc_sat = ACC_LIMIT;
		end else if (acc_sum < -ACC_LIMIT) begin
			acc_sat = -ACC_LIMIT;
		end else begin
			acc_sat = acc_sum;
		end

		g_rnd = {1'b0, gprod_q} + (GP_W + 1)'(HALF);
		g_shr = g_rnd >> GAIN_FRAC_BITS;
		g_next = (g_shr > (GP_W + 1)'(GAIN_CAP)) ? GAIN_CAP : GAIN_W'(g_shr);

		lo = ACC_W'(min_sample);
		hi = signed'(ACC_W'(max_sample));
		if (res_q < lo) begin
			res_cl = lo;
		end else if (res_q > hi) begin
			res_cl = hi;
		end else begin
			res_cl = res_q;
		end

		out_free = !out_valid_q || pop;
		q_pop    = (state_q == S_IDLE) && !q_empty;
		mem_re   = (state_q == S_TAP_RD) && tap_ok;
		mem_we   = (state_q == S_CLAMP) && out_free;
	end

	assign empty      = !out_valid_q;
	assign sample_out = signed'(sample_out_q);
	assign last_out   = last_out_q;

	// history memory: one read or one write per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= smp_q;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (mem_we) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_TAP_RD;
					end
				end
				S_TAP_RD: begin
					state_q <= tap_ok ? S_TAP_MUL : S_ABS;
				end
				S_TAP_MUL: state_q <= S_TAP_ACC;
				S_TAP_ACC: state_q <= S_TAP_RD;
				S_ABS:     state_q <= S_RND;
				S_RND:     state_q <= S_SIGN;
				S_SIGN:    state_q <= S_CLAMP;
				S_CLAMP: begin
					// hold until the result register frees up
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				smp_q  <= e_sample;
				last_q <= e_last;
				wp_q   <= e_wp;
				fidx_q <= e_fidx;
				k_q    <= TAP_CNT_W'(1);
				dist_q <= DIST_W'(tap_spacing);
				off_q  <= step_new;
				step_q <= step_new;
				g_q    <= GAIN_W'(tap_gain);
				acc_q  <= ACC_W'(e_sample) <<< GAIN_FRAC_BITS;
			end
			S_TAP_MUL: begin
				prod_q  <= signed'({1'b0, g_q}) * signed'(rd_q);
				gprod_q <= GP_W'(g_q) * GP_W'(tap_gain);
			end
			S_TAP_ACC: begin
				acc_q  <= acc_sat;
				g_q    <= g_next;
				k_q    <= k_q + TAP_CNT_W'(1);
				dist_q <= dist_q + DIST_W'(tap_spacing);
				off_q  <= off_q + step_q;
			end
			S_ABS: begin
				neg_q <= acc_q < 0;
				mag_q <= (acc_q < 0) ? unsigned'(-acc_q) : unsigned'(acc_q);
			end
			S_RND: begin
				mag_q <= (mag_q + HALF) >> GAIN_FRAC_BITS;
			end
			S_SIGN: begin
				res_q <= neg_q ? -signed'(mag_q) : signed'(mag_q);
			end
			S_CLAMP: begin
				if (out_free) begin
					sample_out_q <= SAMPLE_W'(res_cl);
					last_out_q   <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAP_ACC |-> k_q <= TAP_CNT_W'(reps_eff) && k_q != '0)
		else $error("tap index outside repeat range");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLAMP && out_valid_q && !pop |=> state_q == S_CLAMP)
		else $error("result dropped over a waiting beat");

endmodule

`default_nettype wire

// ===== hw/rtl/multi_tap_echo_saturating_core.sv =====
// ----------------------------------------------------------------------------
// multi_tap_echo_saturating_core
// The tap engine loads each beat, takes every added tap (at most
// min(repeat_count, 8)) through history read, multiply and accumulate,
// then rounds via magnitude and sign, clamps and waits for the result register.
// Samples are handled one at a time; a 4-entry queue absorbs bursts.
// Reset: counters, queue and result valid flag clear asynchronously; config
// returns to defaults; history contents stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_tap_echo_saturating_core #(
	parameter int HISTORY_FRAMES = mte_pkg::HIST_FRAMES_DEF,
	parameter int MAX_CHANNELS   = mte_pkg::MAX_CH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input queue
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [mte_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                 last_in,
	// result register
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [mte_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                 last_out,
	// configuration
	input  logic                                 cfg_write,
	input  logic [mte_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mte_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mte_pkg::*;

	localparam int DEPTH = HISTORY_FRAMES * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(HISTORY_FRAMES + 1);
	localparam int CW    = $clog2(MAX_CHANNELS + 1);
	localparam int Q_W   = SAMPLE_W + 1 + AW + FW + CW;

	logic [DELAY_W-1:0]      delay_q;
	logic [GAIN_REG_W-1:0]   gain_q;
	logic [REPEAT_W-1:0]     reps_q;
	logic [CHAN_W-1:0]       chans_q;
	logic [SAMPLE_W-1:0]     min_q;
	logic [MAX_SAMPLE_W-1:0] max_q;

	logic                    accept;
	logic [AW-1:0]           f_wp;
	logic [FW-1:0]           f_fidx;
	logic [CW-1:0]           f_nch;
	logic [Q_W-1:0]          q_wdata;
	logic [Q_W-1:0]          q_rdata;
	logic                    q_empty;
	logic                    q_pop;
	logic [SAMPLE_W-1:0]     e_sample;
	logic                    e_last;
	logic [AW-1:0]           e_wp;
	logic [FW-1:0]           e_fidx;
	logic [CW-1:0]           e_nch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
			gain_q  <= GAIN_RST;
			reps_q  <= REPEATS_RST;
			chans_q <= CHANNELS_RST;
			min_q   <= MIN_RST;
			max_q   <= MAX_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_DELAY:    delay_q <= cfg_data[DELAY_W-1:0];
				CFG_GAIN:     gain_q  <= cfg_data[GAIN_REG_W-1:0];
				CFG_REPEATS:  reps_q  <= cfg_data[REPEAT_W-1:0];
				CFG_CHANNELS: chans_q <= cfg_data[CHAN_W-1:0];
				CFG_MIN:      min_q   <= cfg_data[SAMPLE_W-1:0];
				CFG_MAX:      max_q   <= cfg_data[MAX_SAMPLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign accept  = push && !full;
	assign q_wdata = {sample_in, last_in, f_wp, f_fidx, f_nch};
	assign {e_sample, e_last, e_wp, e_fidx, e_nch} = q_rdata;

	mte_front #(
		.HISTORY_FRAMES (HISTORY_FRAMES),
		.MAX_CHANNELS   (MAX_CHANNELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.last_in       (last_in),
		.channel_count (chans_q),
		.wp            (f_wp),
		.fidx          (f_fidx),
		.nch           (f_nch)
	);

	mte_fifo #(
		.DATA_W (Q_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (q_wdata),
		.full   (full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	mte_back #(
		.HISTORY_FRAMES (HISTORY_FRAMES),
		.MAX_CHANNELS   (MAX_CHANNELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.e_sample     (signed'(e_sample)),
		.e_last       (e_last),
		.e_wp         (e_wp),
		.e_fidx       (e_fidx),
		.e_nch        (e_nch),
		.tap_spacing  (delay_q),
		.tap_gain     (gain_q),
		.repeat_count (reps_q),
		.min_sample   (signed'(min_q)),
		.max_sample   (max_q),
		.pop          (pop),
		.empty        (empty),
		.sample_out   (sample_out),
		.last_out     (last_out)
	);

endmodule

`default_nettype wire

// ===== test/echo_check.sv =====
// ----------------------------------------------------------------------------
// echo_check
// Watches the sample, result and register channels of the echo core and keeps
// its own copy of the echo history and settings. Every accepted sample gets a
// predicted result, and every popped result is compared against the oldest
// prediction.
// ----------------------------------------------------------------------------
module echo_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic                                full,
	input  logic signed [mte_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                last_in,
	input  logic                                empty,
	input  logic                                pop,
	input  logic signed [mte_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                last_out,
	input  logic                                cfg_write,
	input  logic [mte_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mte_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                  outstanding,
	output int                                  fails
);
	timeunit 1ns;
	timeprecision 1ps;

	import mte_pkg::*;

	localparam int HIST_DEPTH = HIST_FRAMES_DEF * MAX_CH_DEF;
	localparam longint HALF_LSB = longint'(1) <<< (GAIN_FRAC_BITS - 1);

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} echo_t;

	echo_t due_echoes [$];

	// history of raw input samples, addressed like the core's store
	logic [SAMPLE_W-1:0] past_in [HIST_DEPTH];
	int unsigned write_slot  = 0;
	int unsigned frames_done = 0;
	int unsigned chan_pos    = 0;

	logic [DELAY_W-1:0]         delay_reg = DELAY_RST;
	logic [GAIN_REG_W-1:0]      gain_reg  = GAIN_RST;
	logic [REPEAT_W-1:0]        repeat_reg = REPEATS_RST;
	logic [CHAN_W-1:0]          chan_reg  = CHANNELS_RST;
	logic signed [SAMPLE_W-1:0] floor_reg = MIN_RST;
	logic [MAX_SAMPLE_W-1:0]    ceil_reg  = MAX_RST;

	int errs = 0;

	initial outstanding = 0;
	initial fails = 0;

	function automatic int active_channels();
		if (chan_reg == 0)
			return 1;
		if (chan_reg > MAX_CH_DEF)
			return MAX_CH_DEF;
		return int'(chan_reg);
	endfunction

	// current sample plus the weighted taps, rounded and clamped
	function automatic logic signed [SAMPLE_W-1:0] echo_of(
		input logic signed [SAMPLE_W-1:0] x
	);
		longint acc, g, tap, res;
		longint unsigned span, off, addr;
		int nch, reps;
		nch  = active_channels();
		reps = (repeat_reg > MAX_REPEATS) ? MAX_REPEATS : int'(repeat_reg);
		g    = longint'(gain_reg);
		acc  = longint'(x) <<< GAIN_FRAC_BITS;
		if (delay_reg != 0) begin
			for (int k = 1; k <= reps; k++) begin
				span = longint'(k) * longint'(delay_reg);
				if (span <= frames_done) begin
					off  = (span * nch) % HIST_DEPTH;
					addr = (write_slot + HIST_DEPTH - off) % HIST_DEPTH;
					tap  = longint'($signed(past_in[addr]));
					acc  = acc + g * tap;
					if (acc > ACC_LIMIT)
						acc = ACC_LIMIT;
					else if (acc < -ACC_LIMIT)
						acc = -ACC_LIMIT;
				end
				// next power of the gain, rounded and capped
				g = (g * longint'(gain_reg) + HALF_LSB) >>> GAIN_FRAC_BITS;
				if (g > longint'(GAIN_CAP))
					g = longint'(GAIN_CAP);
			end
		end
		if (acc >= 0)
			res = (acc + HALF_LSB) >>> GAIN_FRAC_BITS;
		else
			res = -((HALF_LSB - acc) >>> GAIN_FRAC_BITS);
		// crossed bounds: below the floor takes the floor, the rest take the ceiling
		if (res < longint'(floor_reg))
			res = longint'(floor_reg);
		else if (res > longint'(ceil_reg))
			res = longint'(ceil_reg);
		return res[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		echo_t want;
		if (!arst_n) begin
			due_echoes.delete();
			write_slot  = 0;
			frames_done = 0;
			chan_pos    = 0;
			delay_reg   = DELAY_RST;
			gain_reg    = GAIN_RST;
			repeat_reg  = REPEATS_RST;
			chan_reg    = CHANNELS_RST;
			floor_reg   = MIN_RST;
			ceil_reg    = MAX_RST;
			outstanding <= 0;
		end else begin
			if (pop && !empty) begin
				if (due_echoes.size() == 0) begin
					$error("result beat with nothing expected: sample_out %0d", sample_out);
					errs++;
				end else begin
					want = due_echoes.pop_front();
					if (sample_out !== want.sample) begin
						$error("sample_out: expected %0d, got %0d", want.sample, sample_out);
						errs++;
					end
					if (last_out !== want.last) begin
						$error("last_out: expected %0b, got %0b", want.last, last_out);
						errs++;
					end
				end
			end

			if (cfg_write) begin
				case (cfg_index)
					CFG_DELAY:    delay_reg  = cfg_data[DELAY_W-1:0];
					CFG_GAIN:     gain_reg   = cfg_data[GAIN_REG_W-1:0];
					CFG_REPEATS:  repeat_reg = cfg_data[REPEAT_W-1:0];
					CFG_CHANNELS: chan_reg   = cfg_data[CHAN_W-1:0];
					CFG_MIN:      floor_reg  = cfg_data[SAMPLE_W-1:0];
					CFG_MAX:      ceil_reg   = cfg_data[MAX_SAMPLE_W-1:0];
					default: ;
				endcase
			end

			if (push && !full) begin
				want.sample = echo_of(sample_in);
				want.last   = last_in;
				due_echoes.push_back(want);
				past_in[write_slot] = sample_in;
				write_slot = (write_slot + 1) % HIST_DEPTH;
				if (last_in) begin
					write_slot  = 0;
					frames_done = 0;
					chan_pos    = 0;
				end else begin
					chan_pos++;
					if (chan_pos >= active_channels()) begin
						chan_pos = 0;
						if (frames_done < HIST_FRAMES_DEF)
							frames_done++;
					end
				end
			end

			outstanding <= due_echoes.size();
			fails <= errs;
		end
	end

endmodule

// ===== test/tb_multi_tap_echo_saturating_core.sv =====
// ----------------------------------------------------------------------------
// tb_multi_tap_echo_saturating_core
// Drives clips of interleaved samples through the echo core under a series of
// register settings, with random gaps on the sample side and random stalls on
// the result side. Prediction and comparison live in echo_check.
// ----------------------------------------------------------------------------
module tb_multi_tap_echo_saturating_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mte_pkg::*;

	localparam int ITEMS       = 450;
	localparam int CALM_ITEMS  = 60;
	localparam int DRAIN       = 40;
	localparam int CLIP_MAX    = 40;
	localparam int CYCLE_LIMIT = 300000;

	// indexes the core has no register behind
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                        push      = 1'b0;
	logic                        full;
	logic signed [SAMPLE_W-1:0]  sample_in = '0;
	logic                        last_in   = 1'b0;
	logic                        empty;
	logic                        pop       = 1'b0;
	logic signed [SAMPLE_W-1:0]  sample_out;
	logic                        last_out;
	logic                        cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data  = '0;

	int outstanding;
	int fails;
	int items_sent  = 0;
	int push_pct    = 0;
	int pop_pct     = 0;
	int pop_hold    = 0;
	int cycle_count = 0;

	multi_tap_echo_saturating_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_in  (sample_in),
		.last_in    (last_in),
		.empty      (empty),
		.pop        (pop),
		.sample_out (sample_out),
		.last_out   (last_out),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	echo_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_in   (sample_in),
		.last_in     (last_in),
		.empty       (empty),
		.pop         (pop),
		.sample_out  (sample_out),
		.last_out    (last_out),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fails       (fails)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: stall in random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold != 0) begin
			pop <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else if (pop_pct != 0 && $urandom_range(99) < pop_pct) begin
			pop <= 1'b0;
			pop_hold <= $urandom_range(17, 0);
		end else begin
			pop <= 1'b1;
		end
	end

	function automatic int eff_channels(input int unsigned chans);
		if (chans == 0)
			return 1;
		if (chans > MAX_CH_DEF)
			return MAX_CH_DEF;
		return int'(chans);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3, 4: return $urandom_range(65535) - 32768;
			default: return $urandom();
		endcase
	endfunction

	// one sample beat, with an optional gap in front of it
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic closes);
		if (push_pct != 0 && $urandom_range(99) < push_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(18, 1)) @(posedge clk);
		end
		push      <= 1'b1;
		sample_in <= value;
		last_in   <= closes;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
	endtask

	// drop push and wait until every result has been taken
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// hold cfg_write high; the caller lowers it after the last register
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic set_echo(
		input logic [CFG_DATA_W-1:0] dly, gain, reps, chans, lo, hi
	);
		settle();
		put_reg(CFG_DELAY, dly);
		put_reg(CFG_GAIN, gain);
		put_reg(CFG_REPEATS, reps);
		put_reg(CFG_CHANNELS, chans);
		put_reg(CFG_MIN, lo);
		put_reg(CFG_MAX, hi);
		put_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
		cfg_write <= 1'b0;
	endtask

	initial begin
		int unsigned dly, gain, reps, chans, eff, open_eff, len, clips;
		logic [CFG_DATA_W-1:0] lo, hi;
		bit calm, closes;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: half gain, single tap
		send_sample(20000, 1'b0);
		send_sample(30000, 1'b0);
		send_sample(-32768, 1'b1);

		// full scale with the largest gain drives the result into the output clamp
		pop_pct = 10;
		set_echo(1, 65535, 8, 1, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(0, 1'b1);

		// zero delay adds no taps; crossed bounds give the floor below it, else the ceiling
		set_echo(0, 16384, 3, 1, 100, 50);
		send_sample(0, 1'b0);
		send_sample(200, 1'b0);
		send_sample(-5, 1'b1);

		// repeat count past the top and channel count zero
		set_echo(1, 16384, 15, 0, -32768, 32767);
		send_sample(1, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(1, 1'b0);
		send_sample(-1, 1'b1);

		// channel count past the top acts as eight
		set_echo(1, 12000, 2, 15, 32'h8000_0000, 32'h7FFF_FFFF);
		for (int i = 0; i < 9; i++)
			send_sample(pick_sample(), i == 8);

		// longest delay, zero gain, both bounds at zero
		set_echo(32767, 0, 8, 1, 0, 0);
		send_sample(pick_sample(), 1'b0);
		send_sample(pick_sample(), 1'b1);

		open_eff = 0;
		while (items_sent < ITEMS) begin
			calm = (items_sent + CALM_ITEMS >= ITEMS);
			case ($urandom_range(3))
				0: begin push_pct = 0;  pop_pct = 0;  end
				1: begin push_pct = 8;  pop_pct = 3;  end
				2: begin push_pct = 25; pop_pct = 10; end
				default: begin push_pct = 50; pop_pct = 25; end
			endcase
			if (calm) begin
				push_pct = 0;
				pop_pct  = 0;
			end

			case ($urandom_range(9))
				0: dly = 0;
				1: dly = 32767;
				2: dly = $urandom_range(32767, 1);
				default: dly = $urandom_range(6, 1);
			endcase
			case ($urandom_range(5))
				0: gain = 0;
				1: gain = 65535;
				2: gain = 16384;
				default: gain = $urandom_range(65535);
			endcase
			reps = $urandom_range(15);
			// a clip left open may only shrink its frame, so no entry is read unwritten
			chans = (open_eff != 0) ? $urandom_range(open_eff, 1) : $urandom_range(15);
			case ($urandom_range(3))
				0: lo = 32'h8000_0000;
				1: lo = 0;
				2: lo = -32768;
				default: lo = $urandom() | 32'h8000_0000;
			endcase
			case ($urandom_range(3))
				0: hi = 32'h7FFF_FFFF;
				1: hi = 0;
				2: hi = 32767;
				default: hi = $urandom() >> 1;
			endcase
			set_echo(dly, gain, reps, chans, lo, hi);

			eff   = eff_channels(chans);
			clips = $urandom_range(3, 1);
			for (int c = 0; c < clips; c++) begin
				closes = !(c == clips - 1 && !calm && $urandom_range(4) == 0);
				if (!closes || $urandom_range(9) < 7)
					len = eff * $urandom_range(CLIP_MAX / eff, 1);
				else
					len = $urandom_range(CLIP_MAX, 1);
				for (int i = 0; i < len; i++)
					send_sample(pick_sample(), closes && i == len - 1);
				open_eff = closes ? 0 : eff;
			end
		end

		settle();
		if (fails == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== multi_tap_echo_saturating_core.f =====
hw/rtl/mte_pkg.sv
hw/rtl/mte_front.sv
hw/rtl/mte_fifo.sv
hw/rtl/mte_back.sv
hw/rtl/multi_tap_echo_saturating_core.sv
test/echo_check.sv
test/tb_multi_tap_echo_saturating_core.sv
